// ===== rtl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg : shared types and constants of the business day counter
// Holds the controller state type, the command and status structs between
// controller and datapath, calendar tables and the reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  // field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned COUNT_W = 22;

  // channel widths, packed fields filled up to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // saturation limit of the tally
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // calendar constants
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam int unsigned        DIV25     = 25;
  localparam int unsigned        DIV7      = 7;
  localparam int unsigned        YEAR_BIAS = 400;

  // reciprocals, rounded down: 5242 / 2^17 ~ 1/25, 9362 / 2^16 ~ 1/7
  localparam int unsigned RECIP25   = 5242;
  localparam int unsigned RECIP25_SH = 17;
  localparam int unsigned RECIP7    = 9362;
  localparam int unsigned RECIP7_SH = 16;

  // weekday codes, 0 is sunday
  localparam logic [WDAY_W-1:0] WD_SUN = 3'd0;
  localparam logic [WDAY_W-1:0] WD_MON = 3'd1;
  localparam logic [WDAY_W-1:0] WD_FRI = 3'd5;
  localparam logic [WDAY_W-1:0] WD_SAT = 3'd6;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD25,
    ST_LEAP,
    ST_NORM,
    ST_DIV,
    ST_CORR,
    ST_SUM,
    ST_MOD7,
    ST_WDAY,
    ST_WALK,
    ST_DONE
  } bdc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new item
    logic mod25;  // year / 25 estimates
    logic leap;   // year mod 25 and leap flags
    logic norm;   // clamp days, shifted year
    logic div;    // century estimates, order compare
    logic corr;   // century corrections
    logic sum;    // weekday sum
    logic mod7;   // sum / 7 estimate
    logic wday;   // start weekday
    logic walk;   // one calendar day
    logic emit;   // load the output register
  } bdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic order_err;  // end precedes start
    logic at_end;     // walk date equals end date
    logic out_free;   // output register can take a result
  } bdc_status_t;

  // leap test from the year and its residue mod 25
  function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [DAY_W-1:0] m25);
    is_leap = (y[1:0] == 2'b00) && ((m25 != '0) || (y[3:0] == 4'b0000));
  endfunction

  // days in a month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  // days from march 1 to the first of the month
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    month_offset = 9'd306;
      4'd2:    month_offset = 9'd337;
      4'd3:    month_offset = 9'd0;
      4'd4:    month_offset = 9'd31;
      4'd5:    month_offset = 9'd61;
      4'd6:    month_offset = 9'd92;
      4'd7:    month_offset = 9'd122;
      4'd8:    month_offset = 9'd153;
      4'd9:    month_offset = 9'd184;
      4'd10:   month_offset = 9'd214;
      4'd11:   month_offset = 9'd245;
      default: month_offset = 9'd275;
    endcase
  endfunction

  // month forced into 1..12
  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    if (m < MONTH_JAN) begin
      clamp_month = MONTH_JAN;
    end else if (m > MONTH_DEC) begin
      clamp_month = MONTH_DEC;
    end else begin
      clamp_month = m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/business_day_counter.sv =====
// ----------------------------------------------------------------------------
// business_day_counter : monday-to-friday count between two gregorian dates
// One item carries a start and an end date; one result item carries the
// number of weekdays in the span, both ends included, and an order flag.
//
// Usage
//   in_*  : start and end date, accepted on in_tvalid & in_tready
//   out_* : weekday count and order flag, one result per input item
//   Out-of-range months and days are clamped into the month before use.
//   An end date before the start date returns a zero count, order flag set.
// Sequence
//   After acceptance the set-up steps run (year residues, leap years, start
//   weekday by reciprocal multiplies), then the walk loop steps through each
//   calendar day of the span, then the result is loaded into the output
//   register once it is free. Out-of-order dates skip the walk loop.
//   The sequencer works on one item at a time.
// Reset and stalls
//   rst_n returns the sequencer to idle and drops out_tvalid. A finished
//   result waits in the output register; the next item is taken meanwhile,
//   and its own result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module business_day_counter
  import bdc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  // start_year[13:0], start_month[17:14], start_day[22:18],
  // end_year[36:23], end_month[40:37], end_day[45:41], zero fill
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // weekday_count[21:0], order_error[22], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  wire                   out_tready
);

  bdc_cmd_t    cmd;
  bdc_status_t status;

  // sequencer
  bdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // date arithmetic and walk
  bdc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/bdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdc_ctrl : sequencer of the business day counter
// Steps the datapath through date set-up, the start weekday, the day walk
// and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_ctrl
  import bdc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  bdc_status_t status,
  output bdc_cmd_t    cmd
);

  bdc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD25;
        end
      end
      ST_MOD25: begin
        cmd.mod25 = 1'b1;
        state_nxt = ST_LEAP;
      end
      ST_LEAP: begin
        cmd.leap  = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_MOD7;
      end
      ST_MOD7: begin
        cmd.mod7  = 1'b1;
        state_nxt = ST_WDAY;
      end
      ST_WDAY: begin
        cmd.wday  = 1'b1;
        state_nxt = status.order_err ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.at_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bdc_dp.sv =====
// ----------------------------------------------------------------------------
// bdc_dp : datapath of the business day counter
// Date registers, residue arithmetic for leap years and the start weekday,
// the day-by-day walk with its weekday tally, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_dp
  import bdc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  input  bdc_cmd_t              cmd,
  output bdc_status_t           status,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // dates, the start date doubles as the walk date
  logic [YEAR_W-1:0]  sy_r, ey_r;
  logic [MONTH_W-1:0] sm_r, em_r;
  logic [DAY_W-1:0]   sd_r, ed_r;

  // residue arithmetic
  logic [9:0]         sq25_r, eq25_r;
  logic [DAY_W-1:0]   s_mod25_r;
  logic               e_leap_r;
  logic [14:0]        yy_r;
  logic [7:0]         q100_r;
  logic [5:0]         q400_r;
  logic               err_r;
  logic [14:0]        sum_r;
  logic [11:0]        q7_r;

  // walk
  logic [WDAY_W-1:0]  wd_r;
  logic [COUNT_W-1:0] tally_r;

  // output register
  logic               out_tvalid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_err_r;

  // combinational helpers
  logic [27:0]        sprod, eprod;
  logic [13:0]        s_rem, e_rem;
  logic [DAY_W-1:0]   s_mod25, e_mod25;
  logic               s_leap;
  logic [DAY_W-1:0]   s_len, e_len, walk_len;
  logic [12:0]        x100;
  logic [10:0]        x400;
  logic [25:0]        p100;
  logic [23:0]        p400;
  logic [12:0]        r100;
  logic [10:0]        r400;
  logic [28:0]        p7;
  logic [14:0]        r7;
  logic [14:0]        r7_fix;
  logic               at_end;

  // year / 25 estimates, never above the true quotient
  assign sprod = 28'(sy_r) * 28'(RECIP25);
  assign eprod = 28'(ey_r) * 28'(RECIP25);

  // one correction step brings the remainder below 25
  assign s_rem   = sy_r - 14'(sq25_r) * 14'(DIV25);
  assign e_rem   = ey_r - 14'(eq25_r) * 14'(DIV25);
  assign s_mod25 = (s_rem >= 14'(DIV25)) ? DAY_W'(s_rem - 14'(DIV25)) : DAY_W'(s_rem);
  assign e_mod25 = (e_rem >= 14'(DIV25)) ? DAY_W'(e_rem - 14'(DIV25)) : DAY_W'(e_rem);

  // month lengths for clamping and walking
  assign s_leap    = is_leap(sy_r, s_mod25_r);
  assign s_len     = month_len(sm_r, s_leap);
  assign e_len     = month_len(em_r, e_leap_r);
  assign walk_len  = s_len;

  // century terms of the shifted year
  assign x100 = yy_r[14:2];
  assign x400 = yy_r[14:4];
  assign p100 = 26'(x100) * 26'(RECIP25);
  assign p400 = 24'(x400) * 24'(RECIP25);
  assign r100 = x100 - 13'(q100_r) * 13'(DIV25);
  assign r400 = x400 - 11'(q400_r) * 11'(DIV25);

  // weekday residue
  assign p7     = 29'(sum_r) * 29'(RECIP7);
  assign r7     = sum_r - 15'(q7_r) * 15'(DIV7);
  assign r7_fix = (r7 >= 15'(DIV7)) ? r7 - 15'(DIV7) : r7;

  assign at_end = (sy_r == ey_r) && (sm_r == em_r) && (sd_r == ed_r);

  // date set-up and walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sy_r    <= in_tdata[13:0];
      sm_r    <= clamp_month(in_tdata[17:14]);
      sd_r    <= in_tdata[22:18];
      ey_r    <= in_tdata[36:23];
      em_r    <= clamp_month(in_tdata[40:37]);
      ed_r    <= in_tdata[45:41];
      tally_r <= '0;
    end
    if (cmd.mod25) begin
      sq25_r <= sprod[RECIP25_SH+9:RECIP25_SH];
      eq25_r <= eprod[RECIP25_SH+9:RECIP25_SH];
    end
    if (cmd.leap) begin
      s_mod25_r <= s_mod25;
      e_leap_r  <= is_leap(ey_r, e_mod25);
    end
    // day clamp and march-based year
    if (cmd.norm) begin
      if (sd_r < DAY_FIRST) begin
        sd_r <= DAY_FIRST;
      end else if (sd_r > s_len) begin
        sd_r <= s_len;
      end
      if (ed_r < DAY_FIRST) begin
        ed_r <= DAY_FIRST;
      end else if (ed_r > e_len) begin
        ed_r <= e_len;
      end
      yy_r <= 15'(sy_r) + 15'(YEAR_BIAS) - ((sm_r <= MONTH_FEB) ? 15'd1 : 15'd0);
    end
    if (cmd.div) begin
      q100_r <= p100[RECIP25_SH+7:RECIP25_SH];
      q400_r <= p400[RECIP25_SH+5:RECIP25_SH];
      err_r  <= {ey_r, em_r, ed_r} < {sy_r, sm_r, sd_r};
    end
    if (cmd.corr) begin
      if (r100 >= 13'(DIV25)) begin
        q100_r <= q100_r + 8'd1;
      end
      if (r400 >= 11'(DIV25)) begin
        q400_r <= q400_r + 6'd1;
      end
    end
    // yy + yy/4 - yy/100 + yy/400 + month offset + day + 2, taken mod 7
    if (cmd.sum) begin
      sum_r <= yy_r + 15'(x100) - 15'(q100_r) + 15'(q400_r)
             + 15'(month_offset(sm_r)) + 15'(sd_r) + 15'd2;
    end
    if (cmd.mod7) begin
      q7_r <= p7[RECIP7_SH+11:RECIP7_SH];
    end
    if (cmd.wday) begin
      wd_r <= r7_fix[WDAY_W-1:0];
    end
    // one calendar day: tally, then step to the next date
    if (cmd.walk) begin
      if ((wd_r >= WD_MON) && (wd_r <= WD_FRI) && (tally_r != COUNT_MAX)) begin
        tally_r <= tally_r + 1'b1;
      end
      if (!at_end) begin
        wd_r <= (wd_r == WD_SAT) ? WD_SUN : wd_r + 1'b1;
        if (sd_r == walk_len) begin
          sd_r <= DAY_FIRST;
          if (sm_r == MONTH_DEC) begin
            sm_r <= MONTH_JAN;
            sy_r <= sy_r + 1'b1;
            s_mod25_r <= (s_mod25_r == DAY_W'(DIV25 - 1)) ? '0 : s_mod25_r + 1'b1;
          end else begin
            sm_r <= sm_r + 1'b1;
          end
        end else begin
          sd_r <= sd_r + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r <= err_r ? '0 : tally_r;
      out_err_r   <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_err_r, out_count_r};

  assign status.order_err = err_r;
  assign status.at_end    = at_end;
  assign status.out_free  = !out_tvalid_r || out_tready;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_err_r |-> out_count_r == '0)
    else $error("order error delivered with a non-zero count");

  a_walk_date: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (sm_r >= MONTH_JAN) && (sm_r <= MONTH_DEC) && (sd_r >= DAY_FIRST)
                 && (sd_r <= walk_len) && (wd_r <= WD_SAT))
    else $error("walk date or weekday out of range");

  a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |=> tally_r >= $past(tally_r))
    else $error("weekday tally went backwards");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_tvalid_r || out_tready)
    else $error("result overwrote an item not yet taken");

endmodule

`default_nettype wire
